// ===== design/fpst_pkg.sv =====
// Shared types and constants of the frame packet sequence tracker.
`timescale 1ns / 1ps
package fpst_pkg;

  // Slots at or above this index are tracked but not written.
  localparam int unsigned MaxFramePackets = 512;

  localparam logic [9:0] NormalLenReset  = 10'd360;
  localparam logic [9:0] AutocalLenReset = 10'd135;
  localparam logic [9:0] SlotPtrMax      = 10'd1023;

  typedef enum logic [1:0] {
    CfgIdMode     = 2'd0,
    CfgModeration = 2'd1,
    CfgNormalLen  = 2'd2,
    CfgAutocalLen = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    cfg_reg_e   index;
    logic [9:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic        full_length;
    logic [15:0] pkt_seq;
    logic        tag_autocal;
  } in_item_t;

  typedef struct packed {
    logic        stored;
    logic [8:0]  store_slot;
    logic        id_mismatch;
    logic        subset_done;
    logic [3:0]  subset_index;
    logic [3:0]  subsets_in_frame;
    logic        frame_done;
    logic        frame_autocal;
    logic        frame_align_error;
    logic [31:0] received_count;
    logic [31:0] id_error_count;
  } out_item_t;

endpackage

// ===== design/fpst_if.sv =====
// Valid/ready channel interfaces for headers, results and register writes.
`timescale 1ns / 1ps
interface fpst_in_if;
  logic               valid;
  logic               ready;
  fpst_pkg::in_item_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface fpst_out_if;
  logic                valid;
  logic                ready;
  fpst_pkg::out_item_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface fpst_cfg_if;
  logic               valid;
  logic               ready;
  fpst_pkg::cfg_req_t req;

  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

// ===== design/fpst_cdiv.sv =====
// Quotient by a fixed divisor through a reciprocal multiply (exact for all inputs).
`timescale 1ns / 1ps
module fpst_cdiv #(
  parameter int unsigned X_W     = 16,
  parameter int unsigned DIVISOR = 45
) (
  input  logic [X_W-1:0] x_i,
  output logic [X_W-1:0] q_o
);

  // With the shift at X_W plus the divisor's width and the reciprocal rounded
  // up, the error term stays below 1/DIVISOR, so the floor is exact.
  localparam int unsigned DivW  = $clog2(DIVISOR + 1);
  localparam int unsigned Sh    = X_W + DivW;
  localparam int unsigned MultW = Sh + 1;
  localparam int unsigned ProdW = X_W + MultW;
  localparam longint unsigned Mult = ((64'd1 << Sh) + DIVISOR - 1) / DIVISOR;

  logic [ProdW-1:0] prod;

  assign prod = ProdW'(x_i) * ProdW'(Mult);
  assign q_o  = prod[Sh +: X_W];

endmodule

// ===== design/frame_packet_sequence_tracker.sv =====
// Frame packet sequence tracker: slot placement, gap skipping and frame/subset completion.
//
// One result per accepted header, in order. Sustained rate is one header per
// clock while results are taken. An accepted header goes to the result register
// by way of the input register: the first register stage holds the header with
// its id divided by the subset size, the second closes the slot-tracking loop
// (remainder, skip, completion checks and counters) into the result register.
// The result register and the input register stall together when the result is
// not taken; the input side keeps accepting as long as the stage ahead of it can
// move. No clearing pass after reset. Register writes take effect with the next
// header.
`timescale 1ns / 1ps
module frame_packet_sequence_tracker #(
  parameter int unsigned SUBSET_PACKETS = 45
) (
  input  logic clk_i,
  input  logic rst_ni,
  fpst_in_if.sink    pkt_i,
  fpst_out_if.source res_o,
  fpst_cfg_if.sink   cfg_i
);
  import fpst_pkg::*;

  localparam int unsigned PosW = $clog2(SUBSET_PACKETS + 1);
  localparam logic [PosW-1:0] SubSize = PosW'(SUBSET_PACKETS);
  localparam logic [PosW-1:0] SubLast = PosW'(SUBSET_PACKETS - 1);

  // configuration
  logic       id_mode_q, mod_en_q;
  logic [9:0] norm_len_q, auto_len_q;

  // pipeline
  logic      s1_v_q, out_v_q;
  in_item_t  s1_item_q;
  logic [15:0] s1_pq_q;
  out_item_t out_item_q, out_item_d;
  logic      adv2, in_fire;
  logic [15:0] pid_q_c;

  // tracking state
  logic [9:0]      slot_q, slot_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      sub_cnt_q, sub_cnt_d;
  logic            err_q, err_d;
  logic            sza_q, sza_d;
  logic [31:0]     pkt_cnt_q, pkt_cnt_d;
  logic [31:0]     mis_cnt_q, mis_cnt_d;

  // second-stage working values
  logic [15:0]     pid, qs;
  logic [PosW-1:0] p, j, adv, jn;
  logic            sza, mism, sub_end, sdone, fdone, stored;
  logic [9:0]      npack, nq, nqs;
  logic [16:0]     i_n;

  assign cfg_i.ready = 1'b1;
  assign adv2        = s1_v_q && (!out_v_q || res_o.ready);
  assign pkt_i.ready = !s1_v_q || adv2;
  assign in_fire     = pkt_i.valid && pkt_i.ready;
  assign res_o.valid = out_v_q;
  assign res_o.req   = out_item_q;

  fpst_cdiv #(.X_W(16), .DIVISOR(SUBSET_PACKETS)) u_pid_div (
    .x_i (pkt_i.req.pkt_seq),
    .q_o (pid_q_c)
  );

  fpst_cdiv #(.X_W(10), .DIVISOR(SUBSET_PACKETS)) u_len_div (
    .x_i (npack),
    .q_o (nq)
  );

  // remainders from the quotients; both products never exceed the dividend
  assign pid = s1_item_q.pkt_seq;
  assign qs  = s1_pq_q * 16'(SUBSET_PACKETS);
  assign p   = PosW'(pid - qs);
  assign nqs = nq * 10'(SUBSET_PACKETS);

  assign sza   = (slot_q == 10'd0) ? s1_item_q.tag_autocal : sza_q;
  assign npack = sza ? auto_len_q : norm_len_q;

  always_comb begin
    j       = '0;
    adv     = '0;
    jn      = '0;
    mism    = 1'b0;
    sub_end = 1'b0;
    pos_d   = pos_q;
    i_n     = 17'(slot_q);

    if (!id_mode_q) begin
      j    = (pos_q >= SubSize) ? '0 : pos_q;
      mism = (p != j);
      // a backward id only closes out the current subset
      if (p >= j) adv = p - j + PosW'(1);
      else        adv = SubSize - j;
      jn      = j + adv;
      sub_end = (jn >= SubSize);
      pos_d   = sub_end ? '0 : jn;
      i_n     = 17'(slot_q) + 17'(adv);
    end else begin
      mism = (pid != 16'(slot_q));
      if (pid >= 16'(slot_q)) begin
        i_n     = 17'(pid) + 17'd1;
        sub_end = (p == SubLast);
      end else begin
        i_n     = 17'(npack);
        sub_end = (npack != 10'd0) && (nqs == npack);
      end
    end

    sdone  = sub_end && mod_en_q;
    fdone  = (i_n >= 17'(npack)) && (id_mode_q || sub_end);
    stored = (32'(slot_q) < MaxFramePackets);

    pkt_cnt_d = pkt_cnt_q + 32'd1;
    mis_cnt_d = mis_cnt_q + 32'(mism);
    err_d     = err_q | mism;
    sza_d     = sza;
    sub_cnt_d = sdone ? sub_cnt_q + 4'd1 : sub_cnt_q;
    slot_d    = (i_n > 17'(SlotPtrMax)) ? SlotPtrMax : i_n[9:0];
    if (fdone) begin
      slot_d    = '0;
      pos_d     = '0;
      sub_cnt_d = '0;
      err_d     = 1'b0;
    end

    out_item_d                   = '0;
    out_item_d.stored            = stored;
    out_item_d.store_slot        = stored ? slot_q[8:0] : 9'd0;
    out_item_d.id_mismatch       = mism;
    out_item_d.subset_done       = sdone;
    out_item_d.subset_index      = sdone ? sub_cnt_q : 4'd0;
    out_item_d.subsets_in_frame  = sdone ? nq[3:0] : 4'd0;
    out_item_d.frame_done        = fdone;
    out_item_d.frame_autocal     = fdone && sza;
    out_item_d.frame_align_error = fdone && (err_q | mism);
    out_item_d.received_count    = pkt_cnt_d;
    out_item_d.id_error_count    = mis_cnt_d;

    // short datagram: leaves state alone, reports only the counters
    if (!s1_item_q.full_length) begin
      out_item_d                = '0;
      out_item_d.received_count = pkt_cnt_q;
      out_item_d.id_error_count = mis_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_mode_q  <= 1'b0;
      mod_en_q   <= 1'b0;
      norm_len_q <= NormalLenReset;
      auto_len_q <= AutocalLenReset;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      slot_q     <= '0;
      pos_q      <= '0;
      sub_cnt_q  <= '0;
      err_q      <= 1'b0;
      sza_q      <= 1'b0;
      pkt_cnt_q  <= '0;
      mis_cnt_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.req.index)
          CfgIdMode:     id_mode_q  <= cfg_i.req.data[0];
          CfgModeration: mod_en_q   <= cfg_i.req.data[0];
          CfgNormalLen:  norm_len_q <= cfg_i.req.data;
          CfgAutocalLen: auto_len_q <= cfg_i.req.data;
          default:       ;
        endcase
      end

      if (in_fire)   s1_v_q <= 1'b1;
      else if (adv2) s1_v_q <= 1'b0;

      if (adv2)                 out_v_q <= 1'b1;
      else if (res_o.ready)     out_v_q <= 1'b0;

      if (adv2 && s1_item_q.full_length) begin
        slot_q    <= slot_d;
        pos_q     <= pos_d;
        sub_cnt_q <= sub_cnt_d;
        err_q     <= err_d;
        sza_q     <= sza_d;
        pkt_cnt_q <= pkt_cnt_d;
        mis_cnt_q <= mis_cnt_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= pkt_i.req;
      s1_pq_q   <= pid_q_c;
    end
    if (adv2) out_item_q <= out_item_d;
  end

endmodule
